>>> rtl/core/ole_pkg.sv
// ----------------------------------------------------------------------------
// ole_pkg
// Shared types and constants of the ordered list engine: operation codes,
// status codes, field widths and the per-cell command bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package ole_pkg;

	// default geometry
	localparam int DEPTH_DEF      = 64;
	localparam int ELEM_WIDTH_DEF = 32;

	// fixed field widths of the transaction ports
	localparam int MODE_W   = 2;
	localparam int INDEX_W  = 7;
	localparam int VALUE_W  = 32;
	localparam int DATA_W   = 32;
	localparam int COUNT_W  = 7;
	localparam int STATUS_W = 2;

	// operation codes carried by mode
	typedef enum logic [MODE_W-1:0] {
		MODE_INSERT  = 2'd0,
		MODE_DELETE  = 2'd1,
		MODE_REVERSE = 2'd2,
		MODE_READ    = 2'd3
	} mode_t;

	// result status codes
	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_RANGE = 2'd2
	} status_t;

	// command broadcast to every cell of the row
	typedef struct packed {
		logic ins;  // open a slot at the pointer and load the new value
		logic del;  // close the slot at the pointer
		logic rd;   // present the element at the pointer on the read tap
	} cell_cmd_t;

endpackage : ole_pkg

`default_nettype wire

>>> rtl/core/ole_cell.sv
// ----------------------------------------------------------------------------
// ole_cell
// One storage cell of the list row. Holds one element and, on a broadcast
// command, keeps it, takes the lower or upper neighbor's element, or loads
// the new value, depending on its position relative to the pointer.
// ----------------------------------------------------------------------------
`default_nettype none

module ole_cell #(
	parameter int DEPTH      = ole_pkg::DEPTH_DEF,
	parameter int ELEM_WIDTH = ole_pkg::ELEM_WIDTH_DEF,
	parameter int POS        = 0
) (
	input  wire logic                   clk,
	input  wire ole_pkg::cell_cmd_t     cmd,
	input  wire logic [$clog2(DEPTH)-1:0] ptr,
	input  wire logic [ELEM_WIDTH-1:0]  new_value,
	input  wire logic [ELEM_WIDTH-1:0]  from_lo,
	input  wire logic [ELEM_WIDTH-1:0]  from_hi,
	output      logic [ELEM_WIDTH-1:0]  data,
	output      logic [ELEM_WIDTH-1:0]  rd_tap
);

	localparam int IDX_W = $clog2(DEPTH);
	localparam logic [IDX_W-1:0] MY_POS = IDX_W'(POS);

	logic [ELEM_WIDTH-1:0] elem_q;
	logic                  at_ptr;
	logic                  above_ptr;

	// position relative to the pointer
	assign at_ptr    = (MY_POS == ptr);
	assign above_ptr = (MY_POS > ptr);

	// element register: load, shift up, shift down or hold
	always_ff @(posedge clk) begin
		if (cmd.ins) begin
			if (at_ptr) begin
				elem_q <= new_value;
			end else if (above_ptr) begin
				elem_q <= from_lo;
			end
		end else if (cmd.del) begin
			if (at_ptr || above_ptr) begin
				elem_q <= from_hi;
			end
		end
	end

	assign data = elem_q;

	// read tap, zero unless this cell is addressed
	assign rd_tap = (cmd.rd && at_ptr) ? elem_q : '0;

endmodule : ole_cell

`default_nettype wire

>>> rtl/core/ordered_list_engine.sv
// ----------------------------------------------------------------------------
// ordered_list_engine
// Ordered list of up to DEPTH elements kept in a row of cells. Insert and
// delete shift the cells above the pointer by one place, delete also the
// cell at it; reverse flips a direction flag mapping list positions to cells.
// ----------------------------------------------------------------------------
// result: done is registered from the decode stage, which registers the start
// handshake: start is not accepted while busy; busy is high for the cycle in
//   which the decoded command is applied to the cell row
// reset: arst_n clears the count, direction flag and control; cell contents
//   are not reset and never read before written
// done is a one-cycle strobe; the receiver cannot stall results
`default_nettype none

module ordered_list_engine #(
	parameter int DEPTH      = ole_pkg::DEPTH_DEF,
	parameter int ELEM_WIDTH = ole_pkg::ELEM_WIDTH_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output      logic                          busy,
	input  wire logic [ole_pkg::MODE_W-1:0]    mode,
	input  wire logic [ole_pkg::INDEX_W-1:0]   index,
	input  wire logic [ole_pkg::VALUE_W-1:0]   value,
	output      logic                          done,
	output      logic [ole_pkg::DATA_W-1:0]    read_data,
	output      logic [ole_pkg::COUNT_W-1:0]   count,
	output      logic [ole_pkg::STATUS_W-1:0]  status
);

	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int CMP_W = (CNT_W > ole_pkg::INDEX_W) ? CNT_W : ole_pkg::INDEX_W;
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	// list state
	logic [CNT_W-1:0] cnt_q;
	logic             rev_q;

	// decode stage
	logic                   valid_s1;
	ole_pkg::cell_cmd_t     cmd_s1;
	logic [IDX_W-1:0]       ptr_s1;
	logic [ELEM_WIDTH-1:0]  value_s1;
	ole_pkg::status_t       status_s1;

	// result registers
	logic                   done_q;
	logic [ole_pkg::DATA_W-1:0] read_data_q;
	ole_pkg::status_t       status_q;

	// decode signals
	logic                   accept;
	logic [CMP_W-1:0]       idx_w;
	logic [CMP_W-1:0]       cnt_w;
	logic [CMP_W-1:0]       ptr_ins;
	logic [CMP_W-1:0]       ptr_pos;
	ole_pkg::cell_cmd_t     cmd_d;
	ole_pkg::status_t       status_d;
	logic [CNT_W-1:0]       cnt_d;
	logic                   rev_d;

	// cell row wiring
	logic [ELEM_WIDTH-1:0]  cell_data [DEPTH];
	logic [ELEM_WIDTH-1:0]  cell_tap  [DEPTH];
	logic [ELEM_WIDTH-1:0]  rd_or;

	assign accept = start && !valid_s1;
	assign busy   = valid_s1;

	// pointer arithmetic: list position to cell position
	assign idx_w   = CMP_W'(index);
	assign cnt_w   = CMP_W'(cnt_q);
	assign ptr_ins = rev_q ? (cnt_w - idx_w) : idx_w;
	assign ptr_pos = rev_q ? (cnt_w - idx_w - CMP_W'(1)) : idx_w;

	// command decode and range checks
	always_comb begin
		cmd_d    = '0;
		status_d = ole_pkg::ST_OK;
		cnt_d    = cnt_q;
		rev_d    = rev_q;
		unique case (ole_pkg::mode_t'(mode))
			ole_pkg::MODE_INSERT: begin
				if (cnt_q == FULL_CNT) begin
					status_d = ole_pkg::ST_FULL;
				end else if (idx_w > cnt_w) begin
					status_d = ole_pkg::ST_RANGE;
				end else begin
					cmd_d.ins = 1'b1;
					cnt_d     = cnt_q + CNT_W'(1);
				end
			end
			ole_pkg::MODE_DELETE: begin
				if (idx_w >= cnt_w) begin
					status_d = ole_pkg::ST_RANGE;
				end else begin
					cmd_d.del = 1'b1;
					cnt_d     = cnt_q - CNT_W'(1);
				end
			end
			ole_pkg::MODE_REVERSE: begin
				rev_d = !rev_q;
			end
			ole_pkg::MODE_READ: begin
				if (idx_w >= cnt_w) begin
					status_d = ole_pkg::ST_RANGE;
				end else begin
					cmd_d.rd = 1'b1;
				end
			end
			default: begin
				status_d = ole_pkg::ST_RANGE;
			end
		endcase
	end

	// list state and decode stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			rev_q    <= 1'b0;
			valid_s1 <= 1'b0;
			cmd_s1   <= '0;
		end else begin
			valid_s1 <= accept;
			if (accept) begin
				cnt_q  <= cnt_d;
				rev_q  <= rev_d;
				cmd_s1 <= cmd_d;
			end else begin
				cmd_s1 <= '0;
			end
		end
	end

	// decode stage payload
	always_ff @(posedge clk) begin
		if (accept) begin
			ptr_s1    <= (cmd_d.ins) ? IDX_W'(ptr_ins) : IDX_W'(ptr_pos);
			value_s1  <= ELEM_WIDTH'(value);
			status_s1 <= status_d;
		end
	end

	// row of cells
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [ELEM_WIDTH-1:0] lo_data;
		logic [ELEM_WIDTH-1:0] hi_data;

		if (i == 0) begin : g_first
			assign lo_data = '0;
		end else begin : g_lo
			assign lo_data = cell_data[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign hi_data = '0;
		end else begin : g_hi
			assign hi_data = cell_data[i+1];
		end

		ole_cell #(
			.DEPTH      (DEPTH),
			.ELEM_WIDTH (ELEM_WIDTH),
			.POS        (i)
		) u_cell (
			.clk       (clk),
			.cmd       (cmd_s1),
			.ptr       (ptr_s1),
			.new_value (value_s1),
			.from_lo   (lo_data),
			.from_hi   (hi_data),
			.data      (cell_data[i]),
			.rd_tap    (cell_tap[i])
		);
	end

	// read taps are zero except at the addressed cell
	always_comb begin
		rd_or = '0;
		for (int i = 0; i < DEPTH; i++) begin
			rd_or = rd_or | cell_tap[i];
		end
	end

	// result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= valid_s1;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (valid_s1) begin
			read_data_q <= ole_pkg::DATA_W'(rd_or);
			status_q    <= status_s1;
		end
	end

	assign done      = done_q;
	assign read_data = read_data_q;
	assign count     = ole_pkg::COUNT_W'(cnt_q);
	assign status    = status_q;

	// checks
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy)
		else $error("accepted transaction did not raise busy");

	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |=> done_q && !valid_s1)
		else $error("decoded command did not produce a single result");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= FULL_CNT)
		else $error("live count beyond capacity");

	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		done_q && status_q == ole_pkg::ST_FULL |-> cnt_q == FULL_CNT)
		else $error("full status with free space");

	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done_q && status_q != ole_pkg::ST_OK |-> read_data_q == '0)
		else $error("nonzero read data on error");

endmodule : ordered_list_engine

`default_nettype wire
